// ===== hdl/quadrature_knob_event_decoder_macros.svh =====
// Assertion macros for the knob decoder checker
`ifndef QUADRATURE_KNOB_EVENT_DECODER_MACROS_SVH
`define QUADRATURE_KNOB_EVENT_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, idle in reset
`define QKED_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("knob decoder assertion failed");

// next-cycle implication, sampled on clk, idle in reset
`define QKED_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("knob decoder assertion failed");

`endif

// ===== hdl/qked_pkg.sv =====
// Shared types, constants and phase decode for the knob event decoder
package qked_pkg;

  localparam int COUNTER_WIDTH = 16;
  localparam int STEP_W = 10;
  localparam int IDLE_W = 17;
  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
  localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

  localparam logic [2:0] EV_PRESSED       = 3'd0;
  localparam logic [2:0] EV_RELEASED      = 3'd1;
  localparam logic [2:0] EV_LONG_RELEASED = 3'd2;
  localparam logic [2:0] EV_CW            = 3'd3;
  localparam logic [2:0] EV_CCW           = 3'd4;
  localparam logic [2:0] EV_STOPPED       = 3'd5;

  localparam logic [1:0] ROT_CW      = 2'd0;
  localparam logic [1:0] ROT_CCW     = 2'd1;
  localparam logic [1:0] ROT_STOPPED = 2'd2;

  localparam logic [1:0] REG_STEP_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_IDLE_TIMEOUT     = 2'd1;
  localparam logic [1:0] REG_LONG_PRESS_LIMIT = 2'd2;

  localparam logic [7:0]  RST_STEP_THRESHOLD   = 8'd3;
  localparam logic [15:0] RST_IDLE_TIMEOUT     = 16'd1000;
  localparam logic [15:0] RST_LONG_PRESS_LIMIT = 16'd1000;

  localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};
  localparam logic [COUNTER_WIDTH-1:0] PRESS_MAX = {COUNTER_WIDTH{1'b1}};

  typedef struct packed {
    logic [7:0]  step_threshold;
    logic [15:0] idle_timeout;
    logic [15:0] long_press_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       changed;
    logic       last;
  } ev_t;

  typedef struct packed {
    logic [1:0] cnt;
    ev_t        ev0;
    ev_t        ev1;
  } ev_pair_t;

  function automatic logic signed [1:0] phase_dir(input logic [3:0] code);
    logic signed [1:0] dir;
    unique case (code) inside
      4'hD, 4'h4, 4'h2, 4'hB: dir = 2'sd1;
      4'hE, 4'h7, 4'h1, 4'h8: dir = -2'sd1;
      default:                dir = 2'sd0;
    endcase
    return dir;
  endfunction

endpackage

// ===== hdl/qked_cfg.sv =====
// Configuration registers behind the APB-style port
module qked_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output qked_pkg::cfg_t cfg
);

  qked_pkg::cfg_t cfg_r, cfg_nxt;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        qked_pkg::REG_STEP_THRESHOLD:   cfg_nxt.step_threshold   = cfg_pwdata[7:0];
        qked_pkg::REG_IDLE_TIMEOUT:     cfg_nxt.idle_timeout     = cfg_pwdata[15:0];
        qked_pkg::REG_LONG_PRESS_LIMIT: cfg_nxt.long_press_limit = cfg_pwdata[15:0];
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      qked_pkg::REG_STEP_THRESHOLD:   cfg_prdata = {24'd0, cfg_r.step_threshold};
      qked_pkg::REG_IDLE_TIMEOUT:     cfg_prdata = {16'd0, cfg_r.idle_timeout};
      qked_pkg::REG_LONG_PRESS_LIMIT: cfg_prdata = {16'd0, cfg_r.long_press_limit};
      default:                        cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_threshold   <= qked_pkg::RST_STEP_THRESHOLD;
      cfg_r.idle_timeout     <= qked_pkg::RST_IDLE_TIMEOUT;
      cfg_r.long_press_limit <= qked_pkg::RST_LONG_PRESS_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hdl/qked_core.sv =====
// Per-tick knob state update and event generation
module qked_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tick_vld,
  input  logic               phase_a,
  input  logic               phase_b,
  input  logic               button_level,
  input  qked_pkg::cfg_t     cfg,
  output qked_pkg::ev_pair_t push
);

  logic                                held_r, held_nxt;
  logic [1:0]                          prev_phase_r, prev_phase_nxt;
  logic signed [qked_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [qked_pkg::IDLE_W-1:0]         idle_r, idle_nxt;
  logic [qked_pkg::COUNTER_WIDTH-1:0]  press_r, press_nxt;
  logic [1:0]                          rot_r, rot_nxt;

  logic [1:0]                          phase;
  logic signed [1:0]                   dir;
  logic signed [qked_pkg::STEP_W-1:0]  step_sum;
  logic signed [qked_pkg::STEP_W-1:0]  thr_pos;
  logic signed [qked_pkg::STEP_W-1:0]  thr_neg;
  logic                                btn_ev;
  logic                                rot_ev;
  qked_pkg::ev_t                       btn_word;
  qked_pkg::ev_t                       rot_word;

  assign phase    = {phase_a, phase_b};
  assign dir      = qked_pkg::phase_dir({prev_phase_r, phase});
  assign step_sum = step_r + {{(qked_pkg::STEP_W-2){dir[1]}}, dir};
  assign thr_pos  = $signed({{(qked_pkg::STEP_W-8){1'b0}}, cfg.step_threshold});
  assign thr_neg  = -thr_pos;

  always_comb begin
    held_nxt       = held_r;
    press_nxt      = press_r;
    prev_phase_nxt = phase;
    step_nxt       = step_sum;
    idle_nxt       = idle_r;
    rot_nxt        = rot_r;
    btn_ev         = 1'b0;
    rot_ev         = 1'b0;
    btn_word       = '{kind: qked_pkg::EV_PRESSED, changed: 1'b1, last: 1'b0};
    rot_word       = '{kind: qked_pkg::EV_STOPPED, changed: 1'b0, last: 1'b1};

    if (!button_level && press_r != qked_pkg::PRESS_MAX) begin
      press_nxt = press_r + 1'b1;
    end
    if (held_r && !button_level) begin
      held_nxt = 1'b0;
      btn_ev   = 1'b1;
    end else if (!held_r && button_level) begin
      held_nxt      = 1'b1;
      btn_ev        = 1'b1;
      btn_word.kind = (32'(press_r) > 32'(cfg.long_press_limit))
                      ? qked_pkg::EV_LONG_RELEASED : qked_pkg::EV_RELEASED;
      press_nxt     = '0;
    end

    if (step_sum > thr_pos) begin
      rot_ev           = 1'b1;
      rot_word.kind    = qked_pkg::EV_CW;
      rot_word.changed = (rot_r != qked_pkg::ROT_CW);
      step_nxt         = '0;
      idle_nxt         = '0;
      rot_nxt          = qked_pkg::ROT_CW;
    end else if (step_sum < thr_neg) begin
      rot_ev           = 1'b1;
      rot_word.kind    = qked_pkg::EV_CCW;
      rot_word.changed = (rot_r != qked_pkg::ROT_CCW);
      step_nxt         = '0;
      idle_nxt         = '0;
      rot_nxt          = qked_pkg::ROT_CCW;
    end else if (idle_r > {1'b0, cfg.idle_timeout}) begin
      rot_ev           = 1'b1;
      rot_word.changed = (rot_r != qked_pkg::ROT_STOPPED);
      step_nxt         = '0;
      idle_nxt         = {{(qked_pkg::IDLE_W-1){1'b0}}, 1'b1};
      rot_nxt          = qked_pkg::ROT_STOPPED;
    end else if (idle_r != qked_pkg::IDLE_MAX) begin
      idle_nxt = idle_r + 1'b1;
    end

    btn_word.last = !rot_ev;
  end

  always_comb begin
    push.cnt = '0;
    push.ev0 = btn_word;
    push.ev1 = rot_word;
    if (tick_vld) begin
      push.cnt = {1'b0, btn_ev} + {1'b0, rot_ev};
      if (!btn_ev) begin
        push.ev0 = rot_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= 1'b1;
      prev_phase_r <= 2'd3;
      step_r       <= '0;
      idle_r       <= '0;
      press_r      <= '0;
      rot_r        <= qked_pkg::ROT_STOPPED;
    end else if (tick_vld) begin
      held_r       <= held_nxt;
      prev_phase_r <= prev_phase_nxt;
      step_r       <= step_nxt;
      idle_r       <= idle_nxt;
      press_r      <= press_nxt;
      rot_r        <= rot_nxt;
    end
  end

endmodule

// ===== hdl/qked_evq.sv =====
// Small event queue: up to two words in, one word out per cycle while out_rdy is high
module qked_evq (
  input  logic               clk,
  input  logic               rst_n,
  input  qked_pkg::ev_pair_t push,
  output logic               room,
  output logic               out_vld,
  input  logic               out_rdy,
  output qked_pkg::ev_t      out_word
);

  qked_pkg::ev_t                   mem_r [qked_pkg::EVQ_DEPTH];
  logic [qked_pkg::EVQ_PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [qked_pkg::EVQ_PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [qked_pkg::EVQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [qked_pkg::EVQ_PTR_W-1:0]  wptr_inc;
  logic                            pop;

  assign out_vld  = (cnt_r != '0);
  assign out_word = mem_r[rptr_r];
  assign pop      = out_vld && out_rdy;
  assign room     = (cnt_r <= qked_pkg::EVQ_CNT_W'(qked_pkg::EVQ_DEPTH - 2));
  assign wptr_inc = wptr_r + 1'b1;

  always_comb begin
    wptr_nxt = wptr_r + qked_pkg::EVQ_PTR_W'(push.cnt);
    rptr_nxt = rptr_r + qked_pkg::EVQ_PTR_W'(pop);
    cnt_nxt  = cnt_r + qked_pkg::EVQ_CNT_W'(push.cnt) - qked_pkg::EVQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wptr_r] <= push.ev0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wptr_inc] <= push.ev1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/quadrature_knob_event_decoder.sv =====
// Top level of the quadrature knob event decoder
// Each event word is registered in the event queue when its tick is accepted.
// Throughput: one tick per cycle while in_tready is high; the four-word queue drains
// one word per cycle while out_tready is high; a tick with both events yields two words.
// in_tready drops while fewer than two queue slots are free.
// Reset (rst_n low, synchronous) restores register defaults and knob state.
module quadrature_knob_event_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] phase_a, [1] phase_b, [2] button_level, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] event_kind, [3] changed, zero pad
  output logic        out_tlast,  // last_of_tick
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  qked_pkg::cfg_t     cfg;
  qked_pkg::ev_pair_t push;
  qked_pkg::ev_t      out_word;
  logic               room;
  logic               tick_vld;

  assign in_tready = room;
  assign tick_vld  = in_tvalid && in_tready;

  qked_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  qked_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_vld     (tick_vld),
    .phase_a      (in_tdata[0]),
    .phase_b      (in_tdata[1]),
    .button_level (in_tdata[2]),
    .cfg          (cfg),
    .push         (push)
  );

  qked_evq u_evq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_word (out_word)
  );

  assign out_tdata = {4'd0, out_word.changed, out_word.kind};
  assign out_tlast = out_word.last;

endmodule

// ===== hdl/qked_checker.sv =====
// Port-level checker for the knob event decoder, bound to the top level
`include "quadrature_knob_event_decoder_macros.svh"

module qked_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  `QKED_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `QKED_ASSERT_NOW(a_kind_legal, out_tvalid, out_tdata[2:0] <= qked_pkg::EV_STOPPED)
  `QKED_ASSERT_NOW(a_btn_changed, out_tvalid && out_tdata[2:0] <= qked_pkg::EV_LONG_RELEASED, out_tdata[3])
  `QKED_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[7:4] == 4'd0)

endmodule

bind quadrature_knob_event_decoder qked_checker u_qked_checker (.*);
